// File: rtl/fibonacci_mod_decimal_exponent_defines.svh
// Assertion macros used by the checker file.
`ifndef FIBONACCI_MOD_DECIMAL_EXPONENT_DEFINES_SVH
`define FIBONACCI_MOD_DECIMAL_EXPONENT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define FMDE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked during reset as well.
`define FMDE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/fmde_pkg.sv
package fmde_pkg;

    localparam int MOD_BITS = 20;
    localparam int CNT_BITS = $clog2(MOD_BITS + 1);
    localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(1000000);

    typedef logic [MOD_BITS-1:0] elem_t;

    typedef struct packed {
        logic  start;
        elem_t a;
        elem_t b;
        elem_t m;
    } mm_req_t;

    typedef struct packed {
        logic  done;
        elem_t p;
    } mm_rsp_t;

    // matrix operation codes for the sequencer
    typedef enum logic [1:0] {
        OP_ACC_P  = 2'd0,  // p = p * sq
        OP_SQ_SQ  = 2'd1,  // sq = sq * sq
        OP_ACC_AC = 2'd2   // acc = acc * p
    } mat_op_t;

endpackage

// File: rtl/fmde_mulmod.sv
module fmde_mulmod
    import fmde_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  mm_req_t req,
    output mm_rsp_t rsp
);

    // Serial reduction of a, then of b, mod m: one bit per cycle.
    // Multiply a*b mod m MSB first: p = 2p + bit*a, then reduce; all values < m for m >= 1.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RA   = 4'b0010,
        S_RB   = 4'b0100,
        S_MUL  = 4'b1000
    } st_t;

    st_t                 st_reg, st_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    elem_t               m_reg, m_next;
    elem_t               a_reg, a_next;   // shifting source
    elem_t               r_reg, r_next;   // partial remainder
    elem_t               ra_reg, ra_next; // reduced a
    elem_t               sh_reg, sh_next; // reduced b, shifted out MSB first
    logic                bad;
    logic [MOD_BITS:0]   t2, t3;
    logic [MOD_BITS:0]   u1, u2;
    logic                done_reg;

    assign bad = (m_reg < elem_t'(2));

    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        m_next   = m_reg;
        a_next   = a_reg;
        r_next   = r_reg;
        ra_next  = ra_reg;
        sh_next  = sh_reg;
        rsp.done = done_reg;
        rsp.p    = r_reg;
        t2 = {r_reg, a_reg[MOD_BITS-1]};
        t3 = (t2 >= {1'b0, m_reg}) ? t2 - {1'b0, m_reg} : t2;
        u1 = {r_reg, 1'b0};
        u1 = (u1 >= {1'b0, m_reg}) ? u1 - {1'b0, m_reg} : u1;
        u2 = sh_reg[MOD_BITS-1] ? u1 + {1'b0, ra_reg} : u1;
        u2 = (u2 >= {1'b0, m_reg}) ? u2 - {1'b0, m_reg} : u2;
        case (st_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    m_next   = req.m;
                    a_next   = req.a;
                    sh_next  = req.b;
                    r_next   = '0;
                    cnt_next = '0;
                    st_next  = S_RA;
                end
            end
            S_RA, S_RB:
            begin
                r_next   = t3[MOD_BITS-1:0];
                a_next   = a_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(MOD_BITS - 1))
                begin
                    cnt_next = '0;
                    r_next   = '0;
                    if (st_reg == S_RA)
                    begin
                        ra_next = t3[MOD_BITS-1:0];
                        a_next  = sh_reg;
                        st_next = S_RB;
                    end
                    else
                    begin
                        sh_next = t3[MOD_BITS-1:0];
                        st_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                r_next   = u2[MOD_BITS-1:0];
                sh_next  = sh_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(MOD_BITS - 1))
                begin
                    if (bad)
                        r_next = '0;
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg  <= m_next;
        a_reg  <= a_next;
        r_reg  <= r_next;
        ra_reg <= ra_next;
        sh_reg <= sh_next;
    end

    // a pulse in the cycle after the final step, with r_reg holding the product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (st_reg == S_MUL) && (cnt_reg == CNT_BITS'(MOD_BITS - 1));
    end

endmodule

// File: rtl/fmde_seq.sv
module fmde_seq
    import fmde_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       go,
    input  logic [3:0] digit,
    input  logic       last_digit,
    input  elem_t      m,
    input  logic       mm_done,
    input  elem_t      mm_p,
    output mm_req_t    mm_req,
    output logic       busy,
    output logic       res_valid,
    output elem_t      res_value
);

    // Per digit: p = base^d (square and multiply), acc = acc*p,
    // base = base^10 (square and multiply). Matrix products use the shared
    // serial multiplier, eight products each, summed into the target.
    typedef enum logic [4:0] {
        Q_IDLE  = 5'b00001,
        Q_PICK  = 5'b00010,
        Q_MUL   = 5'b00100,
        Q_WAIT  = 5'b01000,
        Q_ADD   = 5'b10000
    } qst_t;

    typedef enum logic [2:0] {
        PH_POW  = 3'b001,
        PH_ACC  = 3'b010,
        PH_BASE = 3'b100
    } ph_t;

    qst_t        st_reg, st_next;
    ph_t         ph_reg, ph_next;
    elem_t       base_reg [4];
    elem_t       acc_reg [4];
    elem_t       p_reg [4];
    elem_t       sq_reg [4];
    elem_t       t_reg [4];
    logic [3:0]  e_reg, e_next;
    logic        last_reg;
    mat_op_t     op_reg, op_next;
    logic [2:0]  k_reg, k_next;   // product index: entry k[2:1], term k[0]
    elem_t       sum_reg;
    logic        res_valid_reg;
    elem_t       res_reg;
    elem_t       xa, xb;
    logic [1:0]  ri, ci;
    logic [MOD_BITS:0] s1;
    logic        mbad;

    assign mbad = (m < elem_t'(2));
    assign ri   = {k_reg[2], k_reg[0]};
    assign ci   = {k_reg[0], k_reg[1]};

    always_comb
    begin
        case (op_reg)
            OP_ACC_P:  xa = p_reg[ri];
            OP_SQ_SQ:  xa = sq_reg[ri];
            OP_ACC_AC: xa = acc_reg[ri];
            default:   xa = '0;
        endcase
        case (op_reg)
            OP_ACC_P:  xb = sq_reg[ci];
            OP_SQ_SQ:  xb = sq_reg[ci];
            OP_ACC_AC: xb = p_reg[ci];
            default:   xb = '0;
        endcase
    end

    assign mm_req.start = (st_reg == Q_MUL);
    assign mm_req.a     = xa;
    assign mm_req.b     = xb;
    assign mm_req.m     = m;

    assign s1 = {1'b0, sum_reg} + {1'b0, mm_p};

    logic [MOD_BITS:0] s2;
    assign s2 = (s1 >= {1'b0, m}) ? s1 - {1'b0, m} : s1;

    always_comb
    begin
        st_next = st_reg;
        ph_next = ph_reg;
        e_next  = e_reg;
        op_next = op_reg;
        k_next  = k_reg;
        case (st_reg)
            Q_IDLE:
            begin
                if (go)
                begin
                    ph_next = PH_POW;
                    e_next  = digit;
                    st_next = Q_PICK;
                end
            end
            Q_PICK:
            begin
                k_next = '0;
                if (ph_reg == PH_ACC)
                begin
                    op_next = OP_ACC_AC;
                    st_next = Q_MUL;
                end
                else if (e_reg == 4'd0)
                begin
                    if (ph_reg == PH_POW)
                        ph_next = PH_ACC;
                    else
                        st_next = Q_IDLE;
                end
                else if (e_reg[0])
                begin
                    op_next = OP_ACC_P;
                    st_next = Q_MUL;
                end
                else
                begin
                    op_next = OP_SQ_SQ;
                    st_next = Q_MUL;
                end
            end
            Q_MUL:
            begin
                st_next = Q_WAIT;
            end
            Q_WAIT:
            begin
                if (mm_done)
                    st_next = Q_ADD;
            end
            Q_ADD:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == 3'd7)
                begin
                    st_next = Q_PICK;
                    if (op_reg == OP_ACC_P)
                        op_next = OP_SQ_SQ;
                    else if (op_reg == OP_SQ_SQ)
                        e_next = e_reg >> 1;
                    else
                    begin
                        ph_next = PH_BASE;
                        e_next  = 4'd10;
                    end
                    if (op_reg == OP_ACC_P)
                        st_next = Q_MUL;
                end
                else
                    st_next = Q_MUL;
            end
            default:
            begin
                st_next = Q_IDLE;
            end
        endcase
    end

    assign busy = (st_reg != Q_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= Q_IDLE;
            ph_reg        <= PH_POW;
            e_reg         <= '0;
            op_reg        <= OP_ACC_P;
            k_reg         <= '0;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            base_reg[0] <= elem_t'(1);
            base_reg[1] <= elem_t'(1);
            base_reg[2] <= elem_t'(1);
            base_reg[3] <= '0;
            acc_reg[0]  <= elem_t'(1);
            acc_reg[1]  <= '0;
            acc_reg[2]  <= '0;
            acc_reg[3]  <= elem_t'(1);
        end
        else
        begin
            st_reg        <= st_next;
            ph_reg        <= ph_next;
            e_reg         <= e_next;
            op_reg        <= op_next;
            k_reg         <= k_next;
            res_valid_reg <= 1'b0;
            if (st_reg == Q_IDLE && go)
                last_reg <= last_digit;
            if (st_reg == Q_PICK && e_reg == 4'd0 && ph_reg == PH_BASE)
            begin
                if (last_reg)
                begin
                    res_valid_reg <= 1'b1;
                    base_reg[0] <= elem_t'(1);
                    base_reg[1] <= elem_t'(1);
                    base_reg[2] <= elem_t'(1);
                    base_reg[3] <= '0;
                    acc_reg[0]  <= elem_t'(1);
                    acc_reg[1]  <= '0;
                    acc_reg[2]  <= '0;
                    acc_reg[3]  <= elem_t'(1);
                end
                else
                    base_reg <= p_reg;
            end
            if (st_reg == Q_ADD && k_reg == 3'd7 && op_reg == OP_ACC_AC)
            begin
                acc_reg[0] <= t_reg[0];
                acc_reg[1] <= t_reg[1];
                acc_reg[2] <= t_reg[2];
                acc_reg[3] <= s2[MOD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == Q_IDLE && go)
        begin
            // p = identity mod m, sq = base
            p_reg[0] <= mbad ? '0 : elem_t'(1);
            p_reg[1] <= '0;
            p_reg[2] <= '0;
            p_reg[3] <= mbad ? '0 : elem_t'(1);
            sq_reg   <= base_reg;
        end
        if (st_reg == Q_PICK && e_reg == 4'd0 && ph_reg == PH_POW)
        begin
            // keep p for the accumulate; restart power of base for ^10
            sq_reg <= base_reg;
        end
        if (st_reg == Q_PICK && ph_reg == PH_ACC)
            sq_reg <= sq_reg;
        if (st_reg == Q_MUL && !k_reg[0])
            sum_reg <= '0;
        if (st_reg == Q_ADD)
        begin
            if (!k_reg[0])
                sum_reg <= s2[MOD_BITS-1:0];
            else if (k_reg != 3'd7)
                t_reg[k_reg[2:1]] <= s2[MOD_BITS-1:0];
            if (k_reg == 3'd7)
            begin
                if (op_reg == OP_ACC_P)
                begin
                    p_reg[0] <= t_reg[0];
                    p_reg[1] <= t_reg[1];
                    p_reg[2] <= t_reg[2];
                    p_reg[3] <= s2[MOD_BITS-1:0];
                end
                else if (op_reg == OP_SQ_SQ)
                begin
                    sq_reg[0] <= t_reg[0];
                    sq_reg[1] <= t_reg[1];
                    sq_reg[2] <= t_reg[2];
                    sq_reg[3] <= s2[MOD_BITS-1:0];
                end
                else
                begin
                    // start base^10: p = identity, sq = base
                    p_reg[0] <= mbad ? '0 : elem_t'(1);
                    p_reg[1] <= '0;
                    p_reg[2] <= '0;
                    p_reg[3] <= mbad ? '0 : elem_t'(1);
                    sq_reg   <= base_reg;
                end
            end
        end
        if (res_valid_reg == 1'b0 && st_reg == Q_PICK && e_reg == 4'd0
            && ph_reg == PH_BASE)
            res_reg <= mbad ? '0 : (acc_reg[2] >= m ? acc_reg[2] - m : acc_reg[2]);
    end

    assign res_valid = res_valid_reg;
    assign res_value = res_reg;

endmodule

// File: rtl/fibonacci_mod_decimal_exponent.sv
// Each digit takes 7 to 15 matrix products of 8 serial modular multiplies each;
// out_valid rises once the products for the final digit are done.
// A new digit is taken only after the previous one is finished.
// Result waits in an output register; only a final digit is held off meanwhile.
// Reset (rst_n, async low): modulus 1000000, base [[1,1],[1,0]], accum identity.
module fibonacci_mod_decimal_exponent
    import fmde_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [MOD_BITS-1:0] cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [3:0]          digit,
    input  logic                last_digit,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [MOD_BITS-1:0] fib_mod
);

    elem_t   modulus_reg;
    mm_req_t mm_req;
    mm_rsp_t mm_rsp;
    logic    busy, res_valid, go;
    elem_t   res_value;
    logic    out_valid_reg;
    elem_t   out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= MOD_RESET;
        else if (cfg_we)
            modulus_reg <= cfg_wdata;
    end

    fmde_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    // hold a new item off while a result would collide with one still waiting
    assign in_ready = !busy && !res_valid && !(out_valid_reg && last_digit);
    assign go       = in_valid && in_ready;

    fmde_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .digit      (digit),
        .last_digit (last_digit),
        .m          (modulus_reg),
        .mm_done    (mm_rsp.done),
        .mm_p       (mm_rsp.p),
        .mm_req     (mm_req),
        .busy       (busy),
        .res_valid  (res_valid),
        .res_value  (res_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_reg <= res_value;
    end

    assign out_valid = out_valid_reg;
    assign fib_mod   = out_reg;

endmodule

// File: rtl/fmde_checker.sv
`include "fibonacci_mod_decimal_exponent_defines.svh"
module fmde_checker
    import fmde_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [MOD_BITS-1:0] fib_mod
);

    `FMDE_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(fib_mod), "result dropped or changed while stalled")
    `FMDE_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "item accepted while still working")
    `FMDE_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !out_valid, "result shown during reset")

endmodule

bind fibonacci_mod_decimal_exponent fmde_checker u_fmde_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .fib_mod   (fib_mod)
);
